/* rtl/eti_pkg.sv */
// ============================================================================
// eti_pkg: shared constants, tables and helpers of the eased tween interpolator
// Holds the fixed-point format, curve constants, mode and register codes,
// and the exp2 and sine tables built at elaboration.
// ============================================================================
`default_nettype none

package eti_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int ONE         = 1 << FRAC_BITS;
	localparam int SINE_DEPTH  = 256;
	localparam int SINE_AW     = $clog2(SINE_DEPTH);
	localparam int EXP_ENTRIES = 256;
	localparam int EXP_AW      = $clog2(EXP_ENTRIES);
	localparam int MUL_W       = 20;
	localparam int PROD_W      = 2 * MUL_W;
	localparam int MQ_W        = PROD_W - FRAC_BITS;

	// back curve constants, c2 = 1.70158 * 1.525 in Q16
	localparam int C2          = 170060;
	localparam int C2_PLUS_ONE = C2 + ONE;
	// elastic phase offset: 3 - 0.75 in Q16
	localparam int ELASTIC_OFS = 147456;
	// reciprocal of 3 in Q16, exact for 12-bit dividends
	localparam int RECIP3      = 21846;

	// ease modes
	localparam logic [2:0] MODE_LINEAR   = 3'd0;
	localparam logic [2:0] MODE_EXPO_OUT = 3'd1;
	localparam logic [2:0] MODE_EXPO_IN  = 3'd2;
	localparam logic [2:0] MODE_ELASTIC  = 3'd3;
	localparam logic [2:0] MODE_BACK     = 3'd4;

	// register indexes
	localparam logic [2:0] REG_EASE_MODE = 3'd0;
	localparam logic [2:0] REG_DURATION  = 3'd1;
	localparam logic [2:0] REG_DELAY     = 3'd2;
	localparam logic [2:0] REG_START_BOX = 3'd3;
	localparam logic [2:0] REG_END_BOX   = 3'd4;

	// tween phases
	localparam logic [1:0] PH_WAIT = 2'd0;
	localparam logic [1:0] PH_ANIM = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	typedef logic signed [17:0] q_tab_t [256];

	localparam longint Q30         = 64'sd1073741824;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = PI_Q30 / 2;
	localparam longint LN2_Q30     = 64'sd744261118;

	// round a Q30 value to Q16, symmetric about zero
	function automatic longint q30_to_frac(input longint v);
		longint r;
		if (v >= 0) begin
			r = (v + 64'sd8192) >>> 14;
		end else begin
			r = -(((-v) + 64'sd8192) >>> 14);
		end
		return r;
	endfunction

	// Q30 product, truncated toward zero
	function automatic longint q30_mul(input longint a, input longint b);
		longint p;
		longint r;
		p = a * b;
		if (p >= 0) begin
			r = p >>> 30;
		end else begin
			r = -((-p) >>> 30);
		end
		return r;
	endfunction

	function automatic q_tab_t build_sine();
		q_tab_t tab;
		longint x;
		longint x2;
		longint term;
		longint sum;
		bit neg;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x = (64'sd2 * PI_Q30 * longint'(i)) >>> SINE_AW;
			neg = 1'b0;
			if (x >= PI_Q30) begin
				x = x - PI_Q30;
				neg = 1'b1;
			end
			if (x > HALF_PI_Q30) begin
				x = PI_Q30 - x;
			end
			x2 = q30_mul(x, x);
			term = x;
			sum = x;
			// odd Taylor terms, each divided by (2k)(2k+1)
			term = -q30_mul(term, x2) / 64'sd6;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd20;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd42;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd72;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd110;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd156;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd210;
			sum = sum + term;
			term = -q30_mul(term, x2) / 64'sd272;
			sum = sum + term;
			tab[i] = 18'(q30_to_frac(neg ? -sum : sum));
		end
		return tab;
	endfunction

	function automatic q_tab_t build_exp();
		q_tab_t tab;
		longint y;
		longint term;
		longint sum;
		for (int i = 0; i < EXP_ENTRIES; i++) begin
			y = (LN2_Q30 * longint'(i)) >>> EXP_AW;
			term = Q30;
			sum = Q30;
			// series of e^-y, term k divided by k
			term = -q30_mul(term, y);
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd2;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd3;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd4;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd5;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd6;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd7;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd8;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd9;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd10;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd11;
			sum = sum + term;
			term = -q30_mul(term, y) / 64'sd12;
			sum = sum + term;
			tab[i] = 18'(q30_to_frac(sum));
		end
		return tab;
	endfunction

	localparam q_tab_t SINE_TAB = build_sine();
	localparam q_tab_t EXP_TAB  = build_exp();

	// 2^-x for x in Q16, integer part below 16
	function automatic logic [16:0] pow2neg(input logic [19:0] x);
		logic [16:0] base;
		base = EXP_TAB[x[15:8]][16:0];
		return base >> x[19:16];
	endfunction

	// Q16 product, truncated toward zero
	function automatic logic signed [MQ_W-1:0] mulq(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] adj;
		adj = p + (p[PROD_W-1] ? PROD_W'(ONE - 1) : '0);
		return MQ_W'(adj >>> FRAC_BITS);
	endfunction

endpackage

`default_nettype wire

/* rtl/eti_div.sv */
// ============================================================================
// eti_div: restoring divider for the animation fraction
// Computes floor(num * 2^16 / den) for num < den, one quotient bit a cycle.
// ============================================================================
`default_nettype none

module eti_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [15:0] num,
	input  wire logic [15:0] den,
	output logic             done,
	output logic [15:0]      quot
);

	logic [15:0] rem_q;
	logic [15:0] den_q;
	logic [15:0] quot_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] shifted;
	logic        fits;

	// trial subtract of the doubled remainder
	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	// hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd16;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// advance the remainder and shift in quotient bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			den_q  <= den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? 16'(shifted - {1'b0, den_q}) : shifted[15:0];
			quot_q <= {quot_q[14:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

/* rtl/eased_tween_interpolator_core.sv */
// ============================================================================
// eased_tween_interpolator_core: eased box tween with delay and curve select
// Moves four lanes from a start box to an end box along a chosen easing curve.
// ============================================================================
// Usage:
//   Input beats (command, elapsed_ms) on in_valid/in_ready: command 0 restarts
//   the tween into its delay phase, command 1 is a tick of elapsed_ms.
//   Every input beat gives exactly one output beat (four lanes and phase) on
//   out_valid/out_ready. Registers are written through cfg_we/cfg_index/
//   cfg_data and take effect on the next beat; the user must write them
//   only while the block is idle, which the block itself does not enforce.
//   A beat that shows the start or end box goes from idle to the finish
//   state, which waits for a free output register, loads it and raises
//   out_valid. A beat in the animating phase first runs the bit-serial
//   fraction divider and its handoff, then the curve steps, then the four
//   lane products, and then loads the output register, all through one
//   shared 20x20 multiplier with a registered product. One beat is in
//   flight at a time; in_ready is high only while the sequencer is idle.
//   Reset clears phase, time and all registers; no output beat is pending.
//   A stalled receiver holds the output register; the next beat may still be
//   accepted and is computed, then waits until the output register frees.
// ============================================================================
`default_nettype none

module eased_tween_interpolator_core #(
	parameter int LANE_BITS = 12
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          command,
	input  wire logic [9:0]                    elapsed_ms,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [LANE_BITS-1:0]        x_out,
	output logic signed [LANE_BITS-1:0]        y_out,
	output logic signed [LANE_BITS-1:0]        width_out,
	output logic signed [LANE_BITS-1:0]        height_out,
	output logic [1:0]                         phase_out,
	input  wire logic                          cfg_we,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [4*LANE_BITS-1:0]        cfg_data
);

	localparam int BOX_W = 4 * LANE_BITS;
	localparam int SUM_W = LANE_BITS + 4;
	localparam logic signed [SUM_W-1:0] LANE_MAX = SUM_W'((1 << (LANE_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] LANE_MIN = -SUM_W'(1 << (LANE_BITS - 1));

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DIV      = 4'd1;
	localparam logic [3:0] S_EASE     = 4'd2;
	localparam logic [3:0] S_MWAIT    = 4'd3;
	localparam logic [3:0] S_ELA1     = 4'd4;
	localparam logic [3:0] S_ELA2     = 4'd5;
	localparam logic [3:0] S_BACK1    = 4'd6;
	localparam logic [3:0] S_BACK2    = 4'd7;
	localparam logic [3:0] S_BACK3    = 4'd8;
	localparam logic [3:0] S_LANE     = 4'd9;
	localparam logic [3:0] S_LANE_USE = 4'd10;
	localparam logic [3:0] S_FINISH   = 4'd11;

	// configuration
	logic [2:0]       ease_mode_q;
	logic [15:0]      duration_q;
	logic [15:0]      delay_q;
	logic [BOX_W-1:0] start_box_q;
	logic [BOX_W-1:0] end_box_q;

	// tween state and sequencer
	logic [1:0]  phase_q;
	logic [15:0] time_q;
	logic [3:0]  state_q;
	logic [3:0]  ret_q;
	logic [1:0]  lane_q;

	// datapath registers
	logic [15:0]                             t_q;
	logic signed [eti_pkg::MUL_W-1:0]        e_q;
	logic signed [eti_pkg::MUL_W-1:0]        tw_q;
	logic signed [eti_pkg::MUL_W-1:0]        inner_q;
	logic [16:0]                             pw_q;
	logic                                    back_lo_q;
	logic signed [eti_pkg::MUL_W-1:0]        mul_a_q;
	logic signed [eti_pkg::MUL_W-1:0]        mul_b_q;
	logic signed [eti_pkg::PROD_W-1:0]       prod_q;
	logic signed [LANE_BITS-1:0]             res_q [4];
	logic [1:0]                              res_phase_q;
	logic                                    out_valid_q;
	logic signed [LANE_BITS-1:0]             out_lane_q [4];
	logic [1:0]                              out_phase_q;

	// accept-time phase update
	logic        accept;
	logic [1:0]  p0;
	logic [15:0] tc0;
	logic [9:0]  el;
	logic [16:0] tsum;
	logic [15:0] tsat;
	logic [15:0] anim_time;
	logic        check_anim;
	logic        go_anim;
	logic        show_start;
	logic [1:0]  nxt_phase;
	logic [15:0] nxt_time;

	// divider link
	logic        div_done;
	logic [15:0] div_quot;

	// curve helpers
	logic [19:0]                        t10;
	logic [16:0]                        omt;
	logic [19:0]                        omt10;
	logic [19:0]                        ela_num;
	logic signed [eti_pkg::MQ_W-1:0]    mq;
	logic signed [eti_pkg::MQ_W-1:0]    back_v;
	logic signed [LANE_BITS:0]          lane_s;
	logic signed [LANE_BITS:0]          lane_d;
	logic signed [SUM_W-1:0]            lane_sum;
	logic signed [SUM_W-1:0]            lane_sat;

	assign accept   = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;

	// work out where this beat leaves the tween
	always_comb begin
		p0  = command ? phase_q : eti_pkg::PH_WAIT;
		tc0 = command ? time_q : 16'd0;
		el  = command ? elapsed_ms : 10'd0;
		tsum = {1'b0, tc0} + {7'd0, el};
		tsat = tsum[16] ? 16'hFFFF : tsum[15:0];
		anim_time  = tsat;
		check_anim = 1'b0;
		show_start = 1'b0;
		go_anim    = 1'b0;
		nxt_phase  = p0;
		nxt_time   = tc0;
		priority case (p0)
			eti_pkg::PH_WAIT: begin
				if (tsat >= delay_q) begin
					anim_time  = 16'd0;
					check_anim = 1'b1;
				end else begin
					show_start = 1'b1;
					nxt_time   = tsat;
				end
			end
			eti_pkg::PH_ANIM: begin
				check_anim = 1'b1;
			end
			default: begin
				nxt_phase = p0;
			end
		endcase
		if (check_anim) begin
			nxt_time = anim_time;
			if (duration_q != 16'd0 && anim_time < duration_q) begin
				go_anim   = 1'b1;
				nxt_phase = eti_pkg::PH_ANIM;
			end else begin
				nxt_phase = eti_pkg::PH_DONE;
			end
		end
	end

	eti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && go_anim),
		.num    (nxt_time),
		.den    (duration_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// curve operands
	always_comb begin
		t10     = {1'b0, t_q, 3'b000} + {3'b000, t_q, 1'b0};
		omt     = 17'(eti_pkg::ONE) - {1'b0, t_q};
		omt10   = {omt, 3'b000} + {2'b00, omt, 1'b0};
		ela_num = t10 + 20'(eti_pkg::ELASTIC_OFS);
		mq      = eti_pkg::mulq(prod_q);
		back_v  = back_lo_q ? mq : mq + eti_pkg::MQ_W'(2 * eti_pkg::ONE);
		lane_s  = (LANE_BITS + 1)'(signed'(start_box_q[lane_q*LANE_BITS +: LANE_BITS]));
		lane_d  = (LANE_BITS + 1)'(signed'(end_box_q[lane_q*LANE_BITS +: LANE_BITS])) - lane_s;
		lane_sum = SUM_W'(lane_s) + mq[SUM_W-1:0];
		if (lane_sum > LANE_MAX) begin
			lane_sat = LANE_MAX;
		end else if (lane_sum < LANE_MIN) begin
			lane_sat = LANE_MIN;
		end else begin
			lane_sat = lane_sum;
		end
	end

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ease_mode_q <= '0;
			duration_q  <= '0;
			delay_q     <= '0;
			start_box_q <= '0;
			end_box_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eti_pkg::REG_EASE_MODE: ease_mode_q <= cfg_data[2:0];
				eti_pkg::REG_DURATION:  duration_q  <= cfg_data[15:0];
				eti_pkg::REG_DELAY:     delay_q     <= cfg_data[15:0];
				eti_pkg::REG_START_BOX: start_box_q <= cfg_data;
				eti_pkg::REG_END_BOX:   end_box_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequence control and tween state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			lane_q      <= '0;
			phase_q     <= eti_pkg::PH_WAIT;
			time_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// raise the result beat once loaded, drop it when taken
			if (state_q == S_FINISH && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						phase_q <= nxt_phase;
						time_q  <= nxt_time;
						state_q <= go_anim ? S_DIV : S_FINISH;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_EASE;
					end
				end
				S_EASE: begin
					lane_q <= '0;
					unique case (ease_mode_q)
						eti_pkg::MODE_ELASTIC: begin
							state_q <= S_MWAIT;
							ret_q   <= S_ELA1;
						end
						eti_pkg::MODE_BACK: begin
							state_q <= S_MWAIT;
							ret_q   <= S_BACK1;
						end
						default: state_q <= S_LANE;
					endcase
				end
				S_MWAIT: state_q <= ret_q;
				S_ELA1: begin
					state_q <= S_MWAIT;
					ret_q   <= S_ELA2;
				end
				S_ELA2: state_q <= S_LANE;
				S_BACK1: begin
					state_q <= S_MWAIT;
					ret_q   <= S_BACK2;
				end
				S_BACK2: begin
					state_q <= S_MWAIT;
					ret_q   <= S_BACK3;
				end
				S_BACK3: state_q <= S_LANE;
				S_LANE: begin
					state_q <= S_MWAIT;
					ret_q   <= S_LANE_USE;
				end
				S_LANE_USE: begin
					lane_q  <= lane_q + 2'd1;
					state_q <= (lane_q == 2'd3) ? S_FINISH : S_LANE;
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shared multiplier: registered product every cycle
	always_ff @(posedge clk) begin
		prod_q <= mul_a_q * mul_b_q;
	end

	// datapath: curve steps, lane results, output register
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept && !go_anim) begin
					for (int i = 0; i < 4; i++) begin
						res_q[i] <= show_start ? signed'(start_box_q[i*LANE_BITS +: LANE_BITS])
						                       : signed'(end_box_q[i*LANE_BITS +: LANE_BITS]);
					end
					res_phase_q <= show_start ? eti_pkg::PH_WAIT : eti_pkg::PH_DONE;
				end else if (accept) begin
					res_phase_q <= eti_pkg::PH_ANIM;
				end
			end
			S_DIV: begin
				if (div_done) begin
					t_q <= div_quot;
				end
			end
			S_EASE: begin
				unique case (ease_mode_q)
					eti_pkg::MODE_EXPO_OUT: begin
						e_q <= eti_pkg::MUL_W'(eti_pkg::ONE) - {3'b000, eti_pkg::pow2neg(t10)};
					end
					eti_pkg::MODE_EXPO_IN: begin
						e_q <= {3'b000, eti_pkg::pow2neg(omt10)};
					end
					eti_pkg::MODE_ELASTIC: begin
						pw_q    <= eti_pkg::pow2neg(t10);
						mul_a_q <= {8'd0, ela_num[19:8]};
						mul_b_q <= eti_pkg::MUL_W'(eti_pkg::RECIP3);
					end
					eti_pkg::MODE_BACK: begin
						back_lo_q <= !t_q[15];
						if (!t_q[15]) begin
							tw_q    <= {3'b000, t_q, 1'b0};
							mul_b_q <= {3'b000, t_q, 1'b0};
						end else begin
							tw_q    <= {3'b000, t_q, 1'b0} - eti_pkg::MUL_W'(2 * eti_pkg::ONE);
							mul_b_q <= {3'b000, t_q, 1'b0} - eti_pkg::MUL_W'(2 * eti_pkg::ONE);
						end
						mul_a_q <= eti_pkg::MUL_W'(eti_pkg::C2_PLUS_ONE);
					end
					default: e_q <= {4'b0000, t_q};
				endcase
			end
			S_ELA1: begin
				mul_a_q <= {3'b000, pw_q};
				mul_b_q <= eti_pkg::MUL_W'(eti_pkg::SINE_TAB[prod_q[23:16]]);
			end
			S_ELA2: begin
				e_q <= eti_pkg::MUL_W'(mq + eti_pkg::MQ_W'(eti_pkg::ONE));
			end
			S_BACK1: begin
				inner_q <= back_lo_q ? eti_pkg::MUL_W'(mq - eti_pkg::MQ_W'(eti_pkg::C2))
				                     : eti_pkg::MUL_W'(mq + eti_pkg::MQ_W'(eti_pkg::C2));
				mul_a_q <= tw_q;
				mul_b_q <= tw_q;
			end
			S_BACK2: begin
				mul_a_q <= eti_pkg::MUL_W'(mq);
				mul_b_q <= inner_q;
			end
			S_BACK3: begin
				// halve, rounding toward zero
				e_q <= eti_pkg::MUL_W'((back_v + eti_pkg::MQ_W'(back_v[eti_pkg::MQ_W-1])) >>> 1);
			end
			S_LANE: begin
				mul_a_q <= e_q;
				mul_b_q <= eti_pkg::MUL_W'(lane_d);
			end
			S_LANE_USE: begin
				res_q[lane_q] <= lane_sat[LANE_BITS-1:0];
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					for (int i = 0; i < 4; i++) begin
						out_lane_q[i] <= res_q[i];
					end
					out_phase_q <= res_phase_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid  = out_valid_q;
	assign x_out      = out_lane_q[0];
	assign y_out      = out_lane_q[1];
	assign width_out  = out_lane_q[2];
	assign height_out = out_lane_q[3];
	assign phase_out  = out_phase_q;

endmodule

`default_nettype wire

/* tb/eti_checker.sv */
`timescale 1ns / 1ps
// ============================================================================
// eti_checker: result predictor and scoreboard for the eased tween core
// Mirrors the register writes, predicts the box and phase of every input
// beat, and compares each output beat with the oldest prediction.
// ============================================================================

module eti_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               command,
	input  logic [9:0]         elapsed_ms,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [11:0] x_out,
	input  logic signed [11:0] y_out,
	input  logic signed [11:0] width_out,
	input  logic signed [11:0] height_out,
	input  logic [1:0]         phase_out,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data,
	output int                 fails,
	output int                 pending
);
	import eti_pkg::*;

	typedef struct packed {
		logic signed [11:0] x;
		logic signed [11:0] y;
		logic signed [11:0] w;
		logic signed [11:0] h;
		logic [1:0]         ph;
	} box_beat_t;

	localparam longint QONE  = 64'sd65536;
	localparam longint QBIG  = 64'sd1073741824;
	localparam longint PI_BIG = 64'sd3373259426;
	localparam longint LN2_BIG = 64'sd744261118;

	longint sin_lut [256];
	longint exp_lut [256];

	// register mirror and tween state
	logic [2:0]  m_mode;
	logic [15:0] m_dur;
	logic [15:0] m_delay;
	logic [47:0] m_start;
	logic [47:0] m_end;
	logic [1:0]  m_phase;
	int          m_time;

	box_beat_t box_q[$];

	function automatic longint round_to_q16(longint v);
		if (v >= 0) return (v + 64'sd8192) >>> 14;
		return -(((-v) + 64'sd8192) >>> 14);
	endfunction

	// build the sine and 2^-x lookups with series in Q30
	initial begin
		longint a, a2, term, sum;
		bit neg;
		for (int i = 0; i < 256; i++) begin
			a = (64'sd2 * PI_BIG * i) / 256;
			neg = 0;
			if (a >= PI_BIG) begin
				a -= PI_BIG;
				neg = 1;
			end
			if (a > PI_BIG / 2) a = PI_BIG - a;
			a2 = (a * a) / QBIG;
			term = a;
			sum = a;
			for (int k = 1; k <= 8; k++) begin
				term = -(term * a2 / QBIG) / ((2 * k) * (2 * k + 1));
				sum += term;
			end
			sin_lut[i] = round_to_q16(neg ? -sum : sum);
			a = (LN2_BIG * i) / 256;
			term = QBIG;
			sum = QBIG;
			for (int k = 1; k <= 12; k++) begin
				term = -(term * a / QBIG) / k;
				sum += term;
			end
			exp_lut[i] = round_to_q16(sum);
		end
	end

	function automatic longint qmul(longint a, longint b);
		return (a * b) / QONE;
	endfunction

	function automatic longint exp2_neg(longint v);
		longint n;
		n = v >>> 16;
		if (n >= 62) return 0;
		return exp_lut[(v & 64'hFFFF) >>> 8] >>> n;
	endfunction

	function automatic longint curve(longint t);
		longint c2, tw, inner, num;
		c2 = (64'sd25949095 * QONE + 64'sd5000000) / 64'sd10000000;
		case (m_mode)
			MODE_EXPO_OUT: return QONE - exp2_neg(10 * t);
			MODE_EXPO_IN:  return exp2_neg(10 * (QONE - t));
			MODE_ELASTIC: begin
				num = 10 * t - (3 * QONE) / 4 + 3 * QONE;
				return QONE + qmul(exp2_neg(10 * t), sin_lut[((num * 256) / (3 * QONE)) % 256]);
			end
			MODE_BACK: begin
				if (2 * t < QONE) begin
					tw = 2 * t;
					inner = qmul(c2 + QONE, tw) - c2;
					return qmul(qmul(tw, tw), inner) / 2;
				end
				tw = 2 * t - 2 * QONE;
				inner = qmul(c2 + QONE, tw) + c2;
				return (qmul(qmul(tw, tw), inner) + 2 * QONE) / 2;
			end
			default: return t;
		endcase
	endfunction

	function automatic longint lane(logic [47:0] b, int i);
		logic signed [11:0] v;
		v = b[i*12 +: 12];
		return longint'(v);
	endfunction

	function automatic logic signed [11:0] clamp12(longint v);
		if (v > 2047) return 12'sd2047;
		if (v < -2048) return -12'sd2048;
		return v[11:0];
	endfunction

	function automatic box_beat_t show_box(logic [47:0] b, logic [1:0] ph);
		box_beat_t r;
		r.x = clamp12(lane(b, 0));
		r.y = clamp12(lane(b, 1));
		r.w = clamp12(lane(b, 2));
		r.h = clamp12(lane(b, 3));
		r.ph = ph;
		return r;
	endfunction

	// advance the tween by one beat and return the box it shows
	function automatic box_beat_t tween_step(logic cmd, logic [9:0] el);
		int add;
		bit fresh;
		longint t, e, s, d;
		longint v [4];
		box_beat_t r;
		add = el;
		fresh = 0;
		if (!cmd) begin
			m_phase = PH_WAIT;
			m_time = 0;
			add = 0;
		end
		if (m_phase == PH_WAIT) begin
			m_time = (m_time + add > 65535) ? 65535 : m_time + add;
			if (m_time >= m_delay) begin
				m_phase = PH_ANIM;
				m_time = 0;
				fresh = 1;
			end else begin
				return show_box(m_start, PH_WAIT);
			end
		end
		if (m_phase == PH_ANIM) begin
			if (!fresh) m_time = (m_time + add > 65535) ? 65535 : m_time + add;
			if (m_dur != 0 && m_time < m_dur) begin
				t = (longint'(m_time) << 16) / longint'(m_dur);
				e = curve(t);
				for (int i = 0; i < 4; i++) begin
					s = lane(m_start, i);
					d = lane(m_end, i) - s;
					v[i] = s + (e * d) / QONE;
				end
				r.x = clamp12(v[0]);
				r.y = clamp12(v[1]);
				r.w = clamp12(v[2]);
				r.h = clamp12(v[3]);
				r.ph = PH_ANIM;
				return r;
			end
			m_phase = PH_DONE;
		end
		return show_box(m_end, PH_DONE);
	endfunction

	// track writes, queue predictions, compare result beats
	always @(posedge clk or negedge arst_n) begin
		box_beat_t want, got;
		if (!arst_n) begin
			m_mode <= MODE_LINEAR;
			m_dur <= '0;
			m_delay <= '0;
			m_start <= '0;
			m_end <= '0;
			m_phase = PH_WAIT;
			m_time = 0;
			fails <= 0;
			pending <= 0;
			box_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_EASE_MODE: m_mode <= cfg_data[2:0];
					REG_DURATION:  m_dur <= cfg_data[15:0];
					REG_DELAY:     m_delay <= cfg_data[15:0];
					REG_START_BOX: m_start <= cfg_data;
					REG_END_BOX:   m_end <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) box_q.insert(box_q.size(), tween_step(command, elapsed_ms));
			if (out_valid && out_ready) begin
				got = '{x_out, y_out, width_out, height_out, phase_out};
				if (box_q.size() == 0) begin
					fails <= fails + 1;
					if (fails < 10) $display("unexpected result beat: %p", got);
				end else begin
					want = box_q.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.w !== want.w ||
					    got.h !== want.h || got.ph !== want.ph) begin
						fails <= fails + 1;
						if (fails < 10)
							$display({"mismatch at %0t: exp x%0d y%0d w%0d h%0d ph%0d,",
								" got x%0d y%0d w%0d h%0d ph%0d"},
								$realtime, want.x, want.y, want.w, want.h, want.ph,
								got.x, got.y, got.w, got.h, got.ph);
					end
				end
			end
			pending <= box_q.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: stimulus and verdict for the eased tween interpolator core
// Walks every curve through register settings, restarts and tick streams,
// with random idling on both channels; the checker scores the results.
// ============================================================================

module tb;
	import eti_pkg::*;

	localparam int STALL_LIMIT = 3000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic command = 0;
	logic [9:0] elapsed_ms = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [11:0] x_out, y_out, width_out, height_out;
	logic [1:0] phase_out;
	logic cfg_we = 0;
	logic [2:0] cfg_index = '0;
	logic [47:0] cfg_data = '0;
	int fails, pending;
	int sent = 0;
	int quiet_cnt = 0;
	bit calm = 0;
	bit hold_req = 0;
	bit seen_mode [8];

	always #2 clk = ~clk;

	eased_tween_interpolator_core u_top (.*);

	eti_checker u_chk (.*);

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				stall = 250;
			end else if (stall == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 14);
			end
			if (stall > 0) begin
				out_ready <= 0;
				stall--;
			end else begin
				out_ready <= 1;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cnt <= 0;
		else quiet_cnt <= quiet_cnt + 1;
		if (quiet_cnt >= STALL_LIMIT) begin
			$display("[eased_tween_interpolator_core] ERROR");
			$finish;
		end
	end

	// offer one beat, hold until accepted, then maybe go idle
	task automatic send_beat(logic cmd, logic [9:0] el);
		in_valid <= 1;
		command <= cmd;
		elapsed_ms <= el;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
		if (!calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [47:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic setup(logic [2:0] mode, logic [15:0] dur, logic [15:0] dly,
			logic [47:0] sbox, logic [47:0] ebox);
		drain();
		write_reg(REG_EASE_MODE, 48'(mode));
		write_reg(REG_DURATION, 48'(dur));
		write_reg(REG_DELAY, 48'(dly));
		write_reg(REG_START_BOX, sbox);
		write_reg(REG_END_BOX, ebox);
		seen_mode[mode] = 1;
	endtask

	function automatic logic [47:0] rand_box();
		return {$urandom, $urandom};
	endfunction

	// one tween run: restart, then mostly ticks sized to the duration and delay
	task automatic tween_run(int n, logic [15:0] dur, logic [15:0] dly);
		int top;
		top = (int'(dur) + int'(dly)) / 12 + 2;
		if (top > 1023) top = 1023;
		send_beat(0, 10'($urandom));
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0: send_beat(0, 10'($urandom));
				1: send_beat(1, 10'($urandom));
				default: send_beat(1, 10'($urandom_range(0, top)));
			endcase
		end
	endtask

	initial begin
		logic [15:0] dur, dly;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes of the boxes, zero and full timing values
		setup(MODE_BACK, 16'd0, 16'd0, {4{12'h800}}, {4{12'h7FF}});
		send_beat(0, 10'h3FF);
		send_beat(1, 10'h3FF);
		setup(MODE_BACK, 16'd40, 16'd0, {4{12'h800}}, {4{12'h7FF}});
		send_beat(0, 10'd0);
		for (int i = 0; i < 8; i++) send_beat(1, 10'd5);
		setup(MODE_ELASTIC, 16'hFFFF, 16'd3, {4{12'h7FF}}, {4{12'h800}});
		send_beat(1, 10'd1);
		send_beat(0, 10'd0);
		send_beat(1, 10'd2);
		send_beat(1, 10'd1);
		send_beat(1, 10'h3FF);
		// unused register index must leave the mirror alone
		drain();
		write_reg(3'd5, '1);
		write_reg(3'd7, '1);
		send_beat(1, 10'h3FF);
		setup(3'd7, 16'd10, 16'hFFFF, rand_box(), rand_box());
		send_beat(0, 10'd0);
		for (int i = 0; i < 4; i++) send_beat(1, 10'h3FF);

		// long receiver hold-off while beats keep coming
		setup(MODE_EXPO_OUT, 16'd300, 16'd0, rand_box(), rand_box());
		hold_req = 1;
		tween_run(20, 16'd300, 16'd0);
		drain();

		// random runs across all curves and timing settings
		for (int r = 0; r < 18; r++) begin
			case ($urandom_range(0, 5))
				0: dur = 16'd0;
				1: dur = 16'hFFFF;
				2: dur = 16'($urandom_range(1, 20));
				default: dur = 16'($urandom_range(20, 4000));
			endcase
			case ($urandom_range(0, 3))
				0: dly = 16'd0;
				1: dly = 16'($urandom);
				default: dly = 16'($urandom_range(1, 500));
			endcase
			if (r == 17) calm = 1;
			setup(3'(r), dur, dly, rand_box(), rand_box());
			tween_run(35, dur, dly);
		end

		drain();
		repeat (60) @(posedge clk);
		$display("sent %0d beats over 23 register settings; curves 0-7 all exercised: %0b",
			sent, seen_mode.and());
		$display("covered restarts, delay and duration extremes, and a long output stall");
		if (fails == 0) begin
			$display("[eased_tween_interpolator_core] OK");
		end else begin
			$display("[eased_tween_interpolator_core] ERROR");
		end
		$finish;
	end

endmodule
